// ===== hw/rtl/integer_to_ascii_formatter_assert.svh =====
// Assertion macros used by the formatter's checker file.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ITOA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("formatter check failed");

// Next-cycle implication, checked outside reset.
`define ITOA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("formatter check failed");

`endif

// ===== hw/rtl/itoa_pkg.sv =====
// Package with the formatter's codes, constants and controller/datapath types.
`default_nettype none

package itoa_pkg;

  // Mode codes carried by an input item.
  localparam logic [1:0] FUNC_SDEC = 2'd0;
  localparam logic [1:0] FUNC_UDEC = 2'd1;
  localparam logic [1:0] FUNC_HEX  = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A_LOW = 8'h61;
  localparam logic [7:0] CH_F_LOW = 8'h66;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  // Longest digit string and its counter width.
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned CNT_W      = 4;

  // Reciprocal of ten scaled by 2^35; exact quotient for any 32-bit value.
  localparam logic [31:0] RECIP_10   = 32'hcccc_cccd;
  localparam int unsigned RECIP_SHFT = 35;
  localparam logic [3:0]  DEC_BASE   = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic func_bad;
    logic conv_done;
    logic sign_pend;
    logic last_digit;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/itoa_ctrl.sv =====
// Controller state machine of the formatter: accept, convert, emit.
`default_nettype none

module itoa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire itoa_pkg::sts_t sts,
  output itoa_pkg::cmd_t     cmd
);

  itoa_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itoa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itoa_pkg::ST_IDLE: begin
        if (in_valid && !sts.func_bad) begin
          state_nxt = itoa_pkg::ST_CONV;
        end
      end
      itoa_pkg::ST_CONV: begin
        if (sts.conv_done) begin
          state_nxt = itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_EMIT: begin
        if (sts.out_free && !sts.sign_pend && sts.last_digit) begin
          state_nxt = itoa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = itoa_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake and datapath commands.
  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state_r)
      itoa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid && !sts.func_bad;
      end
      itoa_pkg::ST_CONV: begin
        cmd.step = 1'b1;
      end
      itoa_pkg::ST_EMIT: begin
        cmd.emit_sign  = sts.out_free && sts.sign_pend;
        cmd.emit_digit = sts.out_free && !sts.sign_pend;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/itoa_dp.sv =====
// Datapath of the formatter: magnitude, digit stack and output register.
`default_nettype none

module itoa_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [1:0]     in_func,
  input  wire logic [31:0]    in_value,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          out_ascii_char,
  output logic                out_last,
  input  wire itoa_pkg::cmd_t cmd,
  output itoa_pkg::sts_t      sts
);

  localparam int unsigned CW = itoa_pkg::CNT_W;
  localparam int unsigned ND = itoa_pkg::MAX_DIGITS;

  logic [31:0]   mag_r, mag_nxt;
  logic          hex_r;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [3:0]    dig_r   [ND];
  logic [3:0]    dig_nxt [ND];
  logic          out_valid_r;
  logic [7:0]    out_char_r;
  logic          out_last_r;

  logic [63:0]   prod;
  logic [31:0]   quot;
  logic [3:0]    ten_q_lo;
  logic [3:0]    digit;
  logic [3:0]    top_dig;
  logic [7:0]    top_char;
  logic          neg_in;

  // One division step: reciprocal multiply for decimal, nibble shift for hex.
  assign prod     = 64'(mag_r) * 64'(itoa_pkg::RECIP_10);
  assign ten_q_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  always_comb begin
    if (hex_r) begin
      quot  = {4'b0000, mag_r[31:4]};
      digit = mag_r[3:0];
    end else begin
      quot  = 32'(prod[63:itoa_pkg::RECIP_SHFT]);
      digit = mag_r[3:0] - ten_q_lo;
    end
  end

  // Character of the most significant digit still on the stack.
  assign top_dig = dig_r[0];
  always_comb begin
    if (top_dig < itoa_pkg::DEC_BASE) begin
      top_char = itoa_pkg::CH_ZERO + 8'(top_dig);
    end else begin
      top_char = itoa_pkg::CH_A_LOW + 8'(top_dig - itoa_pkg::DEC_BASE);
    end
  end

  // Next values of the magnitude, sign flag, count and digit stack.
  assign neg_in = (in_func == itoa_pkg::FUNC_SDEC) && in_value[31];
  always_comb begin
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    for (int i = 0; i < ND; i++) begin
      dig_nxt[i] = dig_r[i];
    end
    if (cmd.load) begin
      mag_nxt = neg_in ? (~in_value + 32'd1) : in_value;
      neg_nxt = neg_in;
      cnt_nxt = '0;
    end else if (cmd.step) begin
      // Push the new digit on top; it ends up most significant.
      mag_nxt    = quot;
      cnt_nxt    = cnt_r + CW'(1);
      dig_nxt[0] = digit;
      for (int i = 1; i < ND; i++) begin
        dig_nxt[i] = dig_r[i-1];
      end
    end else if (cmd.emit_sign) begin
      neg_nxt = 1'b0;
    end else if (cmd.emit_digit) begin
      // Pop the top digit.
      cnt_nxt = cnt_r - CW'(1);
      for (int i = 0; i < ND - 1; i++) begin
        dig_nxt[i] = dig_r[i+1];
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (cmd.load) begin
      hex_r <= (in_func == itoa_pkg::FUNC_HEX);
    end
    for (int i = 0; i < ND; i++) begin
      dig_r[i] <= dig_nxt[i];
    end
  end

  // Output register: loaded on an emit, cleared once its item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r <= itoa_pkg::CH_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= top_char;
      out_last_r <= (cnt_r == CW'(1));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_char_r;
  assign out_last       = out_last_r;

  // Status for the controller.
  assign sts.func_bad   = (in_func == itoa_pkg::FUNC_NONE);
  assign sts.conv_done  = (quot == 32'd0) || (cnt_r == CW'(ND - 1));
  assign sts.sign_pend  = neg_r;
  assign sts.last_digit = (cnt_r == CW'(1));
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter.
// An input item (in_func, in_value) is taken when in_valid is high and in_stall
// is low. The block holds in_stall low only while idle, so it works on one
// number at a time. A mode of three is accepted and dropped without output.
// Each number leaves as a string of items on the out_ channel, one character
// per item, most significant character first, with out_last set on the final
// digit. A negative signed value is preceded by a minus sign.
// Steps: accept, then one divide step per digit (a reciprocal multiply by ten
// for decimal, a nibble shift for hex), then emission of the characters.
// The output register lets the final character wait while the next number
// is accepted. A stall from the receiver holds the character in place and
// pauses emission. Synchronous reset (rst_n low) returns the controller to
// idle and empties the output register; no conversion survives it.
`default_nettype none

module integer_to_ascii_formatter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_ascii_char,
  output logic             out_last
);

  itoa_pkg::cmd_t cmd;
  itoa_pkg::sts_t sts;

  // Sequencer.
  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Conversion datapath.
  itoa_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_func        (in_func),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ascii_char (out_ascii_char),
    .out_last       (out_last),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/itoa_checker.sv =====
// Port-level checker for the formatter, bound to the top level.
`default_nettype none

`include "integer_to_ascii_formatter_assert.svh"

module itoa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_func,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_ascii_char,
  input wire logic        out_last
);

  logic char_ok;
  logic out_held;
  logic in_take;

  // Legal characters: decimal digit, a to f, or minus sign.
  assign char_ok = ((out_ascii_char >= itoa_pkg::CH_ZERO) &&
                    (out_ascii_char <= itoa_pkg::CH_NINE)) ||
                   ((out_ascii_char >= itoa_pkg::CH_A_LOW) &&
                    (out_ascii_char <= itoa_pkg::CH_F_LOW)) ||
                   (out_ascii_char == itoa_pkg::CH_MINUS);

  // A character is waiting on the receiver.
  assign out_held = out_valid && out_stall;

  // An item with a valid mode is taken on this edge.
  assign in_take = in_valid && !in_stall && (in_func != itoa_pkg::FUNC_NONE);

  // A stalled character holds.
  `ITOA_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_ascii_char) && $stable(out_last))

  // Only legal characters leave the block.
  `ITOA_ASSERT_NOW(a_char_legal, out_valid, char_ok)

  // A minus sign is never the final character.
  `ITOA_ASSERT_NOW(a_minus_not_last, out_valid && (out_ascii_char == itoa_pkg::CH_MINUS), !out_last)

  // A number with a valid mode keeps the input side busy while it converts.
  `ITOA_ASSERT_NEXT(a_busy_after_accept, in_take, in_stall)

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_func        (in_func),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_ascii_char (out_ascii_char),
  .out_last       (out_last)
);

`default_nettype wire
